[hdl/gre_pkg.sv]
`timescale 1ns / 1ps
package gre_pkg;
  localparam int NODES_DEF = 64;
  localparam int NODE_W    = 6;
  localparam int CMD_W     = 3;
  localparam int CNT_W     = 7;

  localparam logic [CMD_W-1:0] CMD_ADD    = 3'd0;
  localparam logic [CMD_W-1:0] CMD_REMOVE = 3'd1;
  localparam logic [CMD_W-1:0] CMD_OPEN   = 3'd2;
  localparam logic [CMD_W-1:0] CMD_CLOSE  = 3'd3;
  localparam logic [CMD_W-1:0] CMD_PATH   = 3'd4;
  localparam logic [CMD_W-1:0] CMD_COUNT  = 3'd5;
  localparam logic [CMD_W-1:0] CMD_LIST   = 3'd6;
  localparam logic [CMD_W-1:0] CMD_UNUSED = 3'd7;
endpackage

[hdl/graph_reachability_engine.sv]
`timescale 1ns / 1ps
// Directed graph engine: the adjacency matrix lives in one synchronous RAM with one row per
// node, the open flags in a register. Pulse start with a command while busy is low; every
// result word appears for exactly one cycle with strobe high and last marks the final word
// of a command. Open, close, bad node indexes and the unused code answer in the cycle after
// start; edge edits and count/list begin with one row read, and an edit then writes the row
// back and answers. Count then scans the node indexes in order up to the highest open
// successor, list the same, with one word per open successor. A path query reads one
// adjacency row per reached open node; reads overlap while other nodes wait, but when none
// waits the next read must wait for the row in flight.
module graph_reachability_engine #(
  parameter int NODES = gre_pkg::NODES_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  output logic                       busy,
  input  logic [gre_pkg::CMD_W-1:0]  cmd,
  input  logic [gre_pkg::NODE_W-1:0] node_a,
  input  logic [gre_pkg::NODE_W-1:0] node_b,
  output logic                       strobe,
  output logic                       flag,
  output logic [gre_pkg::CNT_W-1:0]  open_count,
  output logic [gre_pkg::NODE_W-1:0] neighbour,
  output logic                       neighbour_valid,
  output logic                       last
);
  import gre_pkg::*;

  localparam int IW = (NODES > 1) ? $clog2(NODES) : 1;

  typedef enum logic [1:0] {S_IDLE, S_ROW, S_SCAN, S_PATH} state_t;

  state_t               state;
  logic [CMD_W-1:0]     op;
  logic [IW-1:0]        ia;
  logic [IW-1:0]        ib;
  logic [NODES-1:0]     open_flags;
  logic [NODES-1:0]     row_ok;
  logic [NODES-1:0]     mem [NODES];
  logic [NODES-1:0]     rdata;
  logic                 rd_ok;
  logic [IW-1:0]        raddr;
  logic                 we;
  logic [NODES-1:0]     wdata;
  logic [NODES-1:0]     rem;
  logic [NODES-1:0]     visited;
  logic [NODES-1:0]     pending;
  logic                 rd_pend;
  logic [IW-1:0]        idx;
  logic [CNT_W-1:0]     cnt;

  logic                 accept;
  logic                 a_ok;
  logic                 b_ok;
  logic                 needs_b;
  logic [NODES-1:0]     row;
  logic [NODES-1:0]     bmask;
  logic [NODES-1:0]     imask;
  logic [NODES-1:0]     rem_next;
  logic [CNT_W-1:0]     cnt_next;
  logic [NODES-1:0]     pick_oh;
  logic [IW-1:0]        pick_idx;
  logic [NODES-1:0]     fresh;

  assign busy     = (state != S_IDLE);
  assign accept   = start && !busy;
  assign a_ok     = {1'b0, node_a} < (NODE_W + 1)'(NODES);
  assign b_ok     = {1'b0, node_b} < (NODE_W + 1)'(NODES);
  assign needs_b  = (cmd == CMD_ADD) || (cmd == CMD_REMOVE) || (cmd == CMD_PATH);
  assign row      = rd_ok ? rdata : '0;
  assign bmask    = NODES'(1) << ib;
  assign imask    = NODES'(1) << idx;
  assign rem_next = rem & ~imask;
  assign cnt_next = cnt + CNT_W'(rem[idx]);
  // lowest pending node
  assign pick_oh  = pending & (~pending + NODES'(1));
  assign fresh    = row & open_flags & ~visited;

  always_comb begin
    pick_idx = '0;
    for (int i = 0; i < NODES; i++) begin
      if (pick_oh[i]) pick_idx = pick_idx | IW'(i);
    end
  end

  always_comb begin
    raddr = node_a[IW-1:0];
    if (state == S_PATH) raddr = pick_idx;
  end

  assign we    = (state == S_ROW) && ((op == CMD_ADD) || (op == CMD_REMOVE));
  assign wdata = (op == CMD_ADD) ? (row | bmask) : (row & ~bmask);

  always_ff @(posedge clk) begin
    if (we) mem[ia] <= wdata;
    rdata <= mem[raddr];
    rd_ok <= row_ok[raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= S_IDLE;
      open_flags      <= '1;
      row_ok          <= '0;
      rd_pend         <= 1'b0;
      strobe          <= 1'b0;
      flag            <= 1'b0;
      open_count      <= '0;
      neighbour       <= '0;
      neighbour_valid <= 1'b0;
      last            <= 1'b0;
    end else begin
      strobe          <= 1'b0;
      flag            <= 1'b0;
      open_count      <= '0;
      neighbour       <= '0;
      neighbour_valid <= 1'b0;
      last            <= 1'b0;
      if (we) row_ok[ia] <= 1'b1;
      case (state)
        S_IDLE: begin
          if (accept) begin
            op <= cmd;
            ia <= node_a[IW-1:0];
            ib <= node_b[IW-1:0];
            if (cmd == CMD_UNUSED || !a_ok || (needs_b && !b_ok)) begin
              strobe <= 1'b1;
              last   <= 1'b1;
            end else if (cmd == CMD_OPEN || cmd == CMD_CLOSE) begin
              open_flags[node_a[IW-1:0]] <= (cmd == CMD_OPEN);
              strobe <= 1'b1;
              flag   <= 1'b1;
              last   <= 1'b1;
            end else if (cmd == CMD_PATH) begin
              if (!open_flags[node_a[IW-1:0]] || !open_flags[node_b[IW-1:0]]) begin
                strobe <= 1'b1;
                last   <= 1'b1;
              end else begin
                visited <= NODES'(1) << node_a[IW-1:0];
                pending <= NODES'(1) << node_a[IW-1:0];
                rd_pend <= 1'b0;
                state   <= S_PATH;
              end
            end else begin
              state <= S_ROW;
            end
          end
        end
        S_ROW: begin
          rem <= row & open_flags;
          cnt <= '0;
          idx <= '0;
          if (op == CMD_ADD || op == CMD_REMOVE) begin
            strobe <= 1'b1;
            flag   <= 1'b1;
            last   <= 1'b1;
            state  <= S_IDLE;
          end else if (op == CMD_LIST && row == '0) begin
            strobe <= 1'b1;
            last   <= 1'b1;
            state  <= S_IDLE;
          end else if ((row & open_flags) == '0) begin
            strobe <= 1'b1;
            flag   <= 1'b1;
            last   <= 1'b1;
            state  <= S_IDLE;
          end else begin
            state <= S_SCAN;
          end
        end
        S_SCAN: begin
          rem <= rem_next;
          cnt <= cnt_next;
          idx <= idx + IW'(1);
          if (op == CMD_LIST && rem[idx]) begin
            strobe          <= 1'b1;
            flag            <= 1'b1;
            neighbour       <= NODE_W'(idx);
            neighbour_valid <= 1'b1;
            last            <= (rem_next == '0);
          end else if (op == CMD_COUNT && rem_next == '0) begin
            strobe     <= 1'b1;
            flag       <= 1'b1;
            open_count <= cnt_next;
            last       <= 1'b1;
          end
          if (rem_next == '0) state <= S_IDLE;
        end
        S_PATH: begin
          if (rd_pend && row[ib]) begin
            strobe <= 1'b1;
            flag   <= 1'b1;
            last   <= 1'b1;
            state  <= S_IDLE;
          end else if (pending == '0 && !rd_pend) begin
            strobe <= 1'b1;
            last   <= 1'b1;
            state  <= S_IDLE;
          end else begin
            // issue the lowest pending node, merge the row that came back
            rd_pend <= (pending != '0);
            if (rd_pend) begin
              pending <= (pending & ~pick_oh) | fresh;
              visited <= visited | fresh;
            end else begin
              pending <= pending & ~pick_oh;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef NO_ASSERTIONS
  a_nb_flag: assert property (@(posedge clk) disable iff (rst)
    neighbour_valid |-> strobe && flag)
    else $error("neighbour word without strobe or flag");
  a_last_idle: assert property (@(posedge clk) disable iff (rst)
    strobe && last |-> !busy)
    else $error("final word while still busy");
  a_cnt_strobe: assert property (@(posedge clk) disable iff (rst)
    open_count != '0 |-> strobe && flag && !neighbour_valid)
    else $error("count outside a count word");
  a_busy_start: assert property (@(posedge clk) disable iff (rst)
    $rose(busy) |-> $past(start))
    else $error("busy without a command");
`endif
endmodule

[verif/tb_graph_reachability_engine.sv]
`timescale 1ns / 1ps
module tb_graph_reachability_engine;
  import gre_pkg::*;

  localparam int NODES = 64;
  localparam int WATCHDOG_LIMIT = 20000;

  typedef struct packed {
    logic [CMD_W-1:0]  op;
    logic [NODE_W-1:0] a;
    logic [NODE_W-1:0] b;
  } cmd_word_t;

  typedef struct packed {
    logic              flag;
    logic [CNT_W-1:0]  cnt;
    logic [NODE_W-1:0] nb;
    logic              nbv;
    logic              last;
  } result_word_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic [CMD_W-1:0] cmd = '0;
  logic [NODE_W-1:0] node_a = '0;
  logic [NODE_W-1:0] node_b = '0;
  logic busy, strobe, flag, neighbour_valid, last;
  logic [CNT_W-1:0] open_count;
  logic [NODE_W-1:0] neighbour;

  graph_reachability_engine #(.NODES(NODES)) dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .cmd(cmd),
    .node_a(node_a), .node_b(node_b), .strobe(strobe), .flag(flag),
    .open_count(open_count), .neighbour(neighbour),
    .neighbour_valid(neighbour_valid), .last(last)
  );

  always #5 clk = ~clk;

  cmd_word_t pending_cmds[$];
  result_word_t expected_words[$];
  logic [63:0] graph_rows[NODES];
  logic [63:0] open_nodes;
  int errors = 0;
  int idle_cycles = 0;
  int gap_left = 0;
  bit stim_done = 0;

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 45) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 80);
  endfunction

  function automatic bit search_path(int src, int dst);
    logic [63:0] seen, frontier, row, fresh;
    int p;
    if (!open_nodes[src] || !open_nodes[dst]) return 0;
    seen = 64'd1 << src;
    frontier = seen;
    while (frontier != 0) begin
      p = 0;
      while (!frontier[p]) p++;
      frontier[p] = 1'b0;
      row = graph_rows[p];
      if (row[dst]) return 1;
      fresh = row & open_nodes & ~seen;
      seen |= fresh;
      frontier |= fresh;
    end
    return 0;
  endfunction

  task automatic push_word(logic f, int c, int n, logic v, logic l);
    result_word_t w;
    w.flag = f; w.cnt = c[CNT_W-1:0]; w.nb = n[NODE_W-1:0]; w.nbv = v; w.last = l;
    expected_words.insert(expected_words.size(), w);
  endtask

  task automatic queue_cmd(cmd_word_t c);
    pending_cmds.insert(pending_cmds.size(), c);
  endtask

  // Update the graph copy and queue the words this command produces.
  task automatic apply_command(cmd_word_t c);
    logic [63:0] succ;
    int total, k;
    case (c.op)
      CMD_ADD: begin graph_rows[c.a][c.b] = 1'b1; push_word(1, 0, 0, 0, 1); end
      CMD_REMOVE: begin graph_rows[c.a][c.b] = 1'b0; push_word(1, 0, 0, 0, 1); end
      CMD_OPEN: begin open_nodes[c.a] = 1'b1; push_word(1, 0, 0, 0, 1); end
      CMD_CLOSE: begin open_nodes[c.a] = 1'b0; push_word(1, 0, 0, 0, 1); end
      CMD_PATH: push_word(search_path(c.a, c.b), 0, 0, 0, 1);
      CMD_COUNT: push_word(1, $countones(graph_rows[c.a] & open_nodes), 0, 0, 1);
      CMD_LIST: begin
        succ = graph_rows[c.a] & open_nodes;
        if (graph_rows[c.a] == 0) push_word(0, 0, 0, 0, 1);
        else if (succ == 0) push_word(1, 0, 0, 0, 1);
        else begin
          total = $countones(succ);
          k = 0;
          for (int i = 0; i < 64; i++)
            if (succ[i]) begin
              k++;
              push_word(1, 0, i, 1, k == total);
            end
        end
      end
      default: push_word(0, 0, 0, 0, 1);
    endcase
  endtask

  function automatic cmd_word_t mk(logic [CMD_W-1:0] op, int a, int b);
    cmd_word_t c;
    c.op = op; c.a = a[NODE_W-1:0]; c.b = b[NODE_W-1:0];
    return c;
  endfunction

  // Driver: hold a word on the ports until it is taken, then idle a random gap.
  always @(posedge clk) begin
    if (!rst) begin
      if (start && !busy) begin
        apply_command('{op: cmd, a: node_a, b: node_b});
        gap_left <= pick_gap();
        if (pending_cmds.size() != 0 && pick_gap() == 0) begin
          cmd_word_t c;
          c = pending_cmds.pop_front();
          cmd <= c.op; node_a <= c.a; node_b <= c.b;
        end else
          start <= 1'b0;
      end else if (!start) begin
        if (gap_left > 0) gap_left <= gap_left - 1;
        else if (pending_cmds.size() != 0) begin
          cmd_word_t c;
          c = pending_cmds.pop_front();
          cmd <= c.op; node_a <= c.a; node_b <= c.b;
          start <= 1'b1;
        end
      end
    end
  end

  // Monitor: compare every strobed word with the oldest expectation.
  always @(posedge clk) begin
    if (!rst) begin
      if (strobe || (start && !busy)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (strobe) begin
        if (expected_words.size() == 0) begin
          $display("%0t: unexpected word flag=%0d cnt=%0d nb=%0d nbv=%0d last=%0d", $time,
                   flag, open_count, neighbour, neighbour_valid, last);
          errors++;
        end else begin
          result_word_t e;
          e = expected_words.pop_front();
          if (e.flag !== flag || e.cnt !== open_count || e.nb !== neighbour ||
              e.nbv !== neighbour_valid || e.last !== last) begin
            $display("%0t: mismatch exp flag=%0d cnt=%0d nb=%0d nbv=%0d last=%0d", $time,
                     e.flag, e.cnt, e.nb, e.nbv, e.last);
            $display("%0t:          act flag=%0d cnt=%0d nb=%0d nbv=%0d last=%0d", $time,
                     flag, open_count, neighbour, neighbour_valid, last);
            errors++;
          end
        end
      end
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("FAIL graph_reachability_engine");
        $finish;
      end
    end
  end

  initial begin
    int r, a, b;
    for (int i = 0; i < NODES; i++) graph_rows[i] = '0;
    open_nodes = '1;
    // Directed: empty graph, extremes, cycles, closed ends, unused code.
    queue_cmd(mk(CMD_LIST, 0, 0));
    queue_cmd(mk(CMD_PATH, 0, 63));
    queue_cmd(mk(CMD_ADD, 0, 63));
    queue_cmd(mk(CMD_ADD, 63, 0));
    queue_cmd(mk(CMD_ADD, 63, 63));
    queue_cmd(mk(CMD_ADD, 0, 63));
    queue_cmd(mk(CMD_PATH, 0, 0));
    queue_cmd(mk(CMD_PATH, 63, 63));
    queue_cmd(mk(CMD_COUNT, 63, 0));
    queue_cmd(mk(CMD_LIST, 63, 0));
    queue_cmd(mk(CMD_CLOSE, 63, 0));
    queue_cmd(mk(CMD_PATH, 0, 63));
    queue_cmd(mk(CMD_LIST, 0, 0));
    queue_cmd(mk(CMD_COUNT, 0, 0));
    queue_cmd(mk(CMD_OPEN, 63, 0));
    queue_cmd(mk(CMD_REMOVE, 63, 63));
    queue_cmd(mk(CMD_REMOVE, 5, 9));
    queue_cmd(mk(CMD_UNUSED, 63, 63));
    queue_cmd(mk(CMD_PATH, 1, 2));
    for (int i = 0; i < 64; i++) queue_cmd(mk(CMD_ADD, 42, i));
    queue_cmd(mk(CMD_LIST, 42, 0));
    queue_cmd(mk(CMD_COUNT, 42, 0));
    queue_cmd(mk(CMD_PATH, 42, 7));
    // Random: edge edits, open/close and queries, mostly over a small node set.
    for (int n = 0; n < 175; n++) begin
      r = $urandom_range(0, 99);
      if ($urandom_range(0, 3) == 0) begin
        a = $urandom_range(0, 63); b = $urandom_range(0, 63);
      end else begin
        a = $urandom_range(0, 15); b = $urandom_range(0, 15);
      end
      if (r < 35) queue_cmd(mk(CMD_ADD, a, b));
      else if (r < 45) queue_cmd(mk(CMD_REMOVE, a, b));
      else if (r < 50) queue_cmd(mk(CMD_OPEN, a, b));
      else if (r < 55) queue_cmd(mk(CMD_CLOSE, a, b));
      else if (r < 75) queue_cmd(mk(CMD_PATH, a, b));
      else if (r < 83) queue_cmd(mk(CMD_COUNT, a, b));
      else if (r < 97) queue_cmd(mk(CMD_LIST, a, b));
      else queue_cmd(mk(CMD_UNUSED, a, b));
    end
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    wait (pending_cmds.size() == 0 && !start);
    wait (expected_words.size() == 0);
    repeat (100) @(posedge clk);
    if (errors == 0 && expected_words.size() == 0)
      $display("PASS graph_reachability_engine");
    else
      $display("FAIL graph_reachability_engine");
    $finish;
  end
endmodule

[filelist.f]
hdl/gre_pkg.sv
hdl/graph_reachability_engine.sv
verif/tb_graph_reachability_engine.sv
